FILE: hdl/rtca_pkg.sv
// Shared widths, codes and types for the RTC counter and alarm register block.
package rtca_pkg;

   localparam int ACTION_W    = 2;
   localparam int REG_INDEX_W = 3;
   localparam int WORD_W      = 32;
   localparam int STEP_W      = 30;
   localparam int TIME_W      = 64;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

   typedef enum logic [ACTION_W-1:0] {
      ACTION_TICK  = 2'd0,
      ACTION_READ  = 2'd1,
      ACTION_WRITE = 2'd2
   } action_type;

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_TIME_LO      = 3'd0,
      REG_TIME_HI      = 3'd1,
      REG_ALARM_LO     = 3'd2,
      REG_ALARM_HI     = 3'd3,
      REG_IRQ_ENABLE   = 3'd4,
      REG_CLEAR_ALARM  = 3'd5,
      REG_ALARM_STATUS = 3'd6,
      REG_CLEAR_IRQ    = 3'd7
   } reg_index_type;

endpackage

FILE: hdl/rtca_chan_if.sv
// Valid/ready channel interfaces for the request and response beats.
interface rtca_req_if;
   import rtca_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ACTION_W-1:0]    action;
   logic [REG_INDEX_W-1:0] reg_index;
   logic [WORD_W-1:0]      write_data;

   modport source (output valid, action, reg_index, write_data, input ready);
   modport sink   (input valid, action, reg_index, write_data, output ready);
endinterface

interface rtca_rsp_if;
   import rtca_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] read_data;
   logic              irq_out;

   modport source (output valid, read_data, irq_out, input ready);
   modport sink   (input valid, read_data, irq_out, output ready);
endinterface

FILE: hdl/rtc_counter_alarm_registers_core.sv
// RTC core: 64-bit nanosecond counter, one-shot alarm and interrupt, as a register block.
//
//  channel | dir | beat contents                        | handshake
//  --------+-----+--------------------------------------+------------------------
//  req     | in  | action, reg_index, write_data        | valid/ready
//  rsp     | out | read_data, irq_out                   | valid/ready
//  csr     | in  | step_per_tick (30 bits)              | write enable, no ready
//
//  One beat per cycle sustained while the response side is not stalled; a request
//  passes through the input register, then the response register.
//  The path between them is one 64-bit add (tick) followed by one 64-bit compare
//  (alarm due check), with the register decode muxing in front.
//  Reset is synchronous: all counter/alarm state clears, step_per_tick returns to 1.
//  A stalled response freezes the input stage and all counter/alarm state; the request side
//  keeps accepting while the input register is empty.
module rtc_counter_alarm_registers_core (
   input  logic                        clock,
   input  logic                        reset,
   rtca_req_if.sink                    req,
   rtca_rsp_if.source                  rsp,
   input  logic                        csr_write_enable,
   input  logic [rtca_pkg::STEP_W-1:0] csr_write_data
);
   import rtca_pkg::*;

   // pipeline control
   logic req_fire;
   logic out_stall;
   logic s1_fire;
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;

   // input register (payload, no reset)
   logic [ACTION_W-1:0]    action_ff;
   logic [REG_INDEX_W-1:0] reg_index_ff;
   logic [WORD_W-1:0]      write_data_ff;

   // architectural state
   logic [STEP_W-1:0] step_ff,       step_in;
   logic [TIME_W-1:0] time_count_ff, time_count_in;
   logic [WORD_W-1:0] shadow_ff,     shadow_in;
   logic [WORD_W-1:0] alarm_hi_ff,   alarm_hi_in;
   logic [TIME_W-1:0] alarm_ff,      alarm_in;
   logic              armed_ff,      armed_in;
   logic              pending_ff,    pending_in;
   logic              enabled_ff,    enabled_in;

   // response register
   logic [WORD_W-1:0] read_data_ff, read_data_in;
   logic              irq_ff,       irq_in;

   assign out_stall = out_valid_ff && !rsp.ready;
   assign s1_fire   = s1_valid_ff && !out_stall;
   assign req.ready = !s1_valid_ff || !out_stall;
   assign req_fire  = req.valid && req.ready;

   assign rsp.valid     = out_valid_ff;
   assign rsp.read_data = read_data_ff;
   assign rsp.irq_out   = irq_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // csr writes must land only while idle (user's duty, unchecked); they apply at once
   assign step_in = csr_write_enable ? csr_write_data : step_ff;

   // item execution: register decode, tick add, then the alarm due check
   always_comb begin
      time_count_in = time_count_ff;
      shadow_in     = shadow_ff;
      alarm_hi_in   = alarm_hi_ff;
      alarm_in      = alarm_ff;
      armed_in      = armed_ff;
      pending_in    = pending_ff;
      enabled_in    = enabled_ff;
      read_data_in  = '0;
      if (s1_fire) begin
         unique case (action_type'(action_ff))
            ACTION_TICK: begin
               time_count_in = time_count_ff + TIME_W'(step_ff);
            end
            ACTION_READ: begin
               unique case (reg_index_type'(reg_index_ff))
                  REG_TIME_LO: begin
                     shadow_in    = time_count_ff[TIME_W-1:WORD_W];
                     read_data_in = time_count_ff[WORD_W-1:0];
                  end
                  REG_TIME_HI:      read_data_in = shadow_ff;
                  REG_ALARM_LO:     read_data_in = alarm_ff[WORD_W-1:0];
                  REG_ALARM_HI:     read_data_in = alarm_hi_ff;
                  REG_IRQ_ENABLE:   read_data_in = WORD_W'(enabled_ff);
                  REG_ALARM_STATUS: read_data_in = WORD_W'(armed_ff);
                  REG_CLEAR_ALARM:  read_data_in = '0;
                  REG_CLEAR_IRQ:    read_data_in = '0;
               endcase
            end
            ACTION_WRITE: begin
               unique case (reg_index_type'(reg_index_ff))
                  REG_TIME_LO: begin
                     time_count_in = {time_count_ff[TIME_W-1:WORD_W], write_data_ff};
                  end
                  REG_TIME_HI: begin
                     time_count_in = {write_data_ff, time_count_ff[WORD_W-1:0]};
                  end
                  REG_ALARM_LO: begin
                     alarm_in = {alarm_hi_ff, write_data_ff};
                     armed_in = 1'b1;
                  end
                  REG_ALARM_HI:     alarm_hi_in = write_data_ff;
                  REG_IRQ_ENABLE:   enabled_in  = write_data_ff[0];
                  REG_CLEAR_ALARM:  armed_in    = 1'b0;
                  REG_ALARM_STATUS: ;
                  REG_CLEAR_IRQ:    pending_in  = 1'b0;
               endcase
            end
            default: ;   // unused action code: no effect, reads zero
         endcase
         // alarm already due (including one set in the past) fires on this beat
         if (armed_in && (alarm_in <= time_count_in)) begin
            armed_in   = 1'b0;
            pending_in = 1'b1;
         end
      end
      irq_in = pending_in && enabled_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         step_ff       <= STEP_RESET;
         time_count_ff <= '0;
         shadow_ff     <= '0;
         alarm_hi_ff   <= '0;
         alarm_ff      <= '0;
         armed_ff      <= 1'b0;
         pending_ff    <= 1'b0;
         enabled_ff    <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         step_ff       <= step_in;
         time_count_ff <= time_count_in;
         shadow_ff     <= shadow_in;
         alarm_hi_ff   <= alarm_hi_in;
         alarm_ff      <= alarm_in;
         armed_ff      <= armed_in;
         pending_ff    <= pending_in;
         enabled_ff    <= enabled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff     <= req.action;
         reg_index_ff  <= req.reg_index;
         write_data_ff <= req.write_data;
      end
      if (s1_fire) begin
         read_data_ff <= read_data_in;
         irq_ff       <= irq_in;
      end
   end

   // a held response always reflects the current interrupt state
   a_irq_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (irq_ff == (pending_ff && enabled_ff)))
      else $error("irq_out out of step with pending/enabled state");

   // an armed alarm never sits past its due time
   a_no_stale_alarm: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (alarm_ff > time_count_ff))
      else $error("armed alarm is due but did not fire");

   // request side only back-pressures when the input stage is blocked
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (s1_valid_ff && out_valid_ff && !rsp.ready))
      else $error("request stalled without a blocked response");

   // no state change while the response is stalled
   a_state_frozen_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_stall |=> ($stable(time_count_ff) && $stable(armed_ff) && $stable(pending_ff)))
      else $error("state moved during a response stall");

endmodule
